### design/rswm_pkg.sv
package rswm_pkg;

  // Window lengths and song length
  localparam int OC_WINDOW    = 8;
  localparam int CLIFF_WINDOW = 8;
  localparam int SONG_LENGTH  = 49;

  // Field widths
  localparam int CLIFF_W     = 12;
  localparam int PERIOD_W    = 16;
  localparam int TIME_W      = 20;
  localparam int MODE_W      = 2;
  localparam int NOTE_W      = 6;
  localparam int NUM_CLIFF   = 4;
  localparam int OC_SUM_W    = $clog2(OC_WINDOW + 1);
  localparam int CLIFF_SUM_W = CLIFF_W + $clog2(CLIFF_WINDOW + 1);
  localparam int SONG_POS_W  = (SONG_LENGTH > 1) ? $clog2(SONG_LENGTH) : 1;

  // Register reset values
  localparam logic [CLIFF_W-1:0]  THRESHOLD_RST  = CLIFF_W'(1000);
  localparam logic [PERIOD_W-1:0] RUN_PERIOD_RST = PERIOD_W'(100);
  localparam logic [PERIOD_W-1:0] SONG_PERIOD_RST = PERIOD_W'(500);
  localparam logic [TIME_W-1:0]   ABORT_TIME_RST = TIME_W'(120000);

  // Configuration register indexes
  localparam logic [1:0] REG_CLIFF_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_RUN_PERIOD      = 2'd1;
  localparam logic [1:0] REG_SONG_PERIOD     = 2'd2;
  localparam logic [1:0] REG_ABORT_TIME      = 2'd3;

  // Reported mode codes
  localparam logic [MODE_W-1:0] MODE_CODE_RUN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_STOP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_DONE = 2'd2;

  typedef enum logic [2:0] {
    MODE_RUN  = 3'b001,
    MODE_STOP = 3'b010,
    MODE_DONE = 3'b100
  } mode_t;

  typedef struct packed {
    logic                              drop_l;
    logic                              drop_r;
    logic                              oc_l;
    logic                              oc_r;
    logic [NUM_CLIFF-1:0][CLIFF_W-1:0] cliff;
  } sensor_t;

  typedef struct packed {
    logic drop;
    logic oc;
    logic cliff;
  } danger_t;

  // floor(1.5 * thr), saturated to the sample range
  function automatic logic [CLIFF_W-1:0] cliff_preload(input logic [CLIFF_W-1:0] thr);
    logic [CLIFF_W:0] p;
    p = {1'b0, thr} + {2'b00, thr[CLIFF_W-1:1]};
    return p[CLIFF_W] ? {CLIFF_W{1'b1}} : p[CLIFF_W-1:0];
  endfunction

endpackage

### design/rswm_windows.sv
module rswm_windows import rswm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,       // advance all windows with smp
  input  sensor_t             smp,
  input  logic                reload,     // threshold write: refill cliff windows
  input  logic [CLIFF_W-1:0]  new_thr,
  input  logic [CLIFF_W-1:0]  thr,
  output danger_t             danger
);

  logic [OC_WINDOW-1:0] oc_win_l, oc_win_l_next;
  logic [OC_WINDOW-1:0] oc_win_r, oc_win_r_next;
  logic [OC_SUM_W-1:0]  oc_sum_l, oc_sum_l_next;
  logic [OC_SUM_W-1:0]  oc_sum_r, oc_sum_r_next;

  logic [NUM_CLIFF-1:0][CLIFF_WINDOW-1:0][CLIFF_W-1:0] cl_win, cl_win_next;
  logic [NUM_CLIFF-1:0][CLIFF_SUM_W-1:0]               cl_sum, cl_sum_next;

  logic [CLIFF_W-1:0]     pre_rst, pre_new;
  logic [CLIFF_SUM_W-1:0] limit;
  logic                   cliff_hit;

  assign pre_rst = cliff_preload(THRESHOLD_RST);
  assign pre_new = cliff_preload(new_thr);
  assign limit   = CLIFF_SUM_W'(thr) * CLIFF_SUM_W'(CLIFF_WINDOW);

  // Windows are shift lines: entry 0 newest, top entry leaves next
  always_comb begin
    for (int i = OC_WINDOW - 1; i > 0; i--) begin
      oc_win_l_next[i] = oc_win_l[i-1];
      oc_win_r_next[i] = oc_win_r[i-1];
    end
    oc_win_l_next[0] = smp.oc_l;
    oc_win_r_next[0] = smp.oc_r;
    oc_sum_l_next = oc_sum_l - OC_SUM_W'(oc_win_l[OC_WINDOW-1]) + OC_SUM_W'(smp.oc_l);
    oc_sum_r_next = oc_sum_r - OC_SUM_W'(oc_win_r[OC_WINDOW-1]) + OC_SUM_W'(smp.oc_r);

    cliff_hit = 1'b0;
    for (int c = 0; c < NUM_CLIFF; c++) begin
      for (int i = CLIFF_WINDOW - 1; i > 0; i--) begin
        cl_win_next[c][i] = cl_win[c][i-1];
      end
      cl_win_next[c][0] = smp.cliff[c];
      cl_sum_next[c] = cl_sum[c] - CLIFF_SUM_W'(cl_win[c][CLIFF_WINDOW-1])
                     + CLIFF_SUM_W'(smp.cliff[c]);
      if (cl_sum_next[c] <= limit) begin
        cliff_hit = 1'b1;
      end
    end

    danger.drop  = smp.drop_l | smp.drop_r;
    danger.oc    = ({oc_sum_l_next, 1'b0} >= (OC_SUM_W + 1)'(OC_WINDOW)) ||
                   ({oc_sum_r_next, 1'b0} >= (OC_SUM_W + 1)'(OC_WINDOW));
    danger.cliff = cliff_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oc_win_l <= '0;
      oc_win_r <= '0;
      oc_sum_l <= '0;
      oc_sum_r <= '0;
      for (int c = 0; c < NUM_CLIFF; c++) begin
        for (int i = 0; i < CLIFF_WINDOW; i++) begin
          cl_win[c][i] <= pre_rst;
        end
        cl_sum[c] <= CLIFF_SUM_W'(pre_rst) * CLIFF_SUM_W'(CLIFF_WINDOW);
      end
    end else begin
      if (step) begin
        oc_win_l <= oc_win_l_next;
        oc_win_r <= oc_win_r_next;
        oc_sum_l <= oc_sum_l_next;
        oc_sum_r <= oc_sum_r_next;
      end
      if (reload) begin
        for (int c = 0; c < NUM_CLIFF; c++) begin
          for (int i = 0; i < CLIFF_WINDOW; i++) begin
            cl_win[c][i] <= pre_new;
          end
          cl_sum[c] <= CLIFF_SUM_W'(pre_new) * CLIFF_SUM_W'(CLIFF_WINDOW);
        end
      end else if (step) begin
        cl_win <= cl_win_next;
        cl_sum <= cl_sum_next;
      end
    end
  end

endmodule

### design/robot_safety_window_monitor.sv
// Path: an accepted input beat passes the input register, then the result
//   register, on its way to its result beat.
// Throughput: one beat per cycle; the input register moves on whenever the
//   result register is empty or being taken, so both sides run back to back.
// Reset (rst, synchronous, active high): registers to their defaults, mode
//   running, overcurrent windows clear, cliff windows preloaded to 1.5 x threshold.
module robot_safety_window_monitor import rswm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // sensor poll stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] wheel_drop_left, [1] wheel_drop_right, [2] overcurrent_left,
  // [3] overcurrent_right, [15:4] cliff_left, [27:16] cliff_right,
  // [39:28] cliff_front_left, [51:40] cliff_front_right,
  // [52] advance_button, [72:53] elapsed_ms, [79:73] zero
  input  logic [79:0] s_axis_tdata,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] mode, [2] drive_stop, [3] led_red, [4] play_note, [10:5] note_index,
  // [11] drop_hazard, [12] overcurrent_hazard, [13] cliff_detected, [15:14] zero
  output logic [15:0] m_axis_tdata,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  // config registers
  logic [CLIFF_W-1:0]  cliff_threshold;
  logic [PERIOD_W-1:0] run_period_ms;
  logic [PERIOD_W-1:0] song_period_ms;
  logic [TIME_W-1:0]   abort_time_ms;

  // input stage
  logic              s1_valid;
  sensor_t           s1_smp;
  logic              s1_adv;
  logic [TIME_W-1:0] s1_elapsed;

  // control state
  mode_t                 mode, mode_next;
  logic [SONG_POS_W-1:0] song_pos, song_pos_next;

  // result stage
  logic        out_valid;
  logic [15:0] out_data, out_data_next;

  logic    fire, cfg_wr, thr_wr, step;
  logic    abort_run, abort_song;
  danger_t danger, flags;
  logic    drive_stop, led_red, play_note;
  logic [NOTE_W-1:0] note_index;
  logic [MODE_W-1:0] mode_code;

  // input stage moves into the result register when that is free or taken
  assign fire          = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || fire;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign thr_wr    = cfg_wr && (cfg_index == REG_CLIFF_THRESHOLD);

  // abort compare without wrap
  assign abort_run  = ({1'b0, s1_elapsed} + (TIME_W + 1)'(run_period_ms))
                      >= {1'b0, abort_time_ms};
  assign abort_song = ({1'b0, s1_elapsed} + (TIME_W + 1)'(song_period_ms))
                      >= {1'b0, abort_time_ms};

  rswm_windows u_windows (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .smp     (s1_smp),
    .reload  (thr_wr),
    .new_thr (cfg_data[CLIFF_W-1:0]),
    .thr     (cliff_threshold),
    .danger  (danger)
  );

  // mode sequencing for the beat in the input stage
  always_comb begin
    mode_next     = mode;
    song_pos_next = song_pos;
    step          = 1'b0;
    flags         = '0;
    drive_stop    = 1'b0;
    led_red       = 1'b0;
    play_note     = 1'b0;
    note_index    = '0;
    unique case (mode)
      MODE_RUN: begin
        if (abort_run) begin
          mode_next  = MODE_DONE;
          drive_stop = 1'b1;
          led_red    = 1'b1;
        end else begin
          step  = fire;
          flags = danger;
          if (danger.drop || danger.oc || danger.cliff) begin
            mode_next  = MODE_STOP;
            drive_stop = 1'b1;
          end
        end
      end
      MODE_STOP: begin
        if (s1_adv) begin
          // resume, with the danger check in the same poll
          step      = fire;
          flags     = danger;
          mode_next = MODE_RUN;
          if (danger.drop || danger.oc || danger.cliff) begin
            mode_next  = MODE_STOP;
            drive_stop = 1'b1;
          end
        end else if (abort_song) begin
          mode_next  = MODE_DONE;
          drive_stop = 1'b1;
          led_red    = 1'b1;
        end else begin
          play_note     = 1'b1;
          note_index    = NOTE_W'(song_pos);
          song_pos_next = (song_pos == SONG_POS_W'(SONG_LENGTH - 1)) ? '0 : song_pos + 1'b1;
        end
      end
      default: begin
        // done: latched for good
        mode_next = MODE_DONE;
      end
    endcase

    unique case (mode_next)
      MODE_RUN:  mode_code = MODE_CODE_RUN;
      MODE_STOP: mode_code = MODE_CODE_STOP;
      default:   mode_code = MODE_CODE_DONE;
    endcase

    out_data_next = {2'b00, flags.cliff, flags.oc, flags.drop, note_index,
                     play_note, led_red, drive_stop, mode_code};
  end

  // config register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cliff_threshold <= THRESHOLD_RST;
      run_period_ms   <= RUN_PERIOD_RST;
      song_period_ms  <= SONG_PERIOD_RST;
      abort_time_ms   <= ABORT_TIME_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_CLIFF_THRESHOLD: cliff_threshold <= cfg_data[CLIFF_W-1:0];
        REG_RUN_PERIOD:      run_period_ms   <= cfg_data[PERIOD_W-1:0];
        REG_SONG_PERIOD:     song_period_ms  <= cfg_data[PERIOD_W-1:0];
        REG_ABORT_TIME:      abort_time_ms   <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_smp.drop_l   <= s_axis_tdata[0];
      s1_smp.drop_r   <= s_axis_tdata[1];
      s1_smp.oc_l     <= s_axis_tdata[2];
      s1_smp.oc_r     <= s_axis_tdata[3];
      s1_smp.cliff[0] <= s_axis_tdata[15:4];
      s1_smp.cliff[1] <= s_axis_tdata[27:16];
      s1_smp.cliff[2] <= s_axis_tdata[39:28];
      s1_smp.cliff[3] <= s_axis_tdata[51:40];
      s1_adv          <= s_axis_tdata[52];
      s1_elapsed      <= s_axis_tdata[72:53];
    end
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_RUN;
      song_pos  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        mode     <= mode_next;
        song_pos <= song_pos_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= out_data_next;
    end
  end

endmodule
